@@ rtl/wpft_pkg.sv @@
// Package for the word-pair frequency table: sizes, derived widths, codes and
// the command and status structs that pass between the controller and the datapath.
// Has no dependencies.
package wpft_pkg;

    // Store sizes and field widths.
    localparam int FIRST_ENTRIES = 256;
    localparam int PAIR_ENTRIES  = 1024;
    localparam int WORD_ID_BITS  = 16;
    localparam int COUNT_BITS    = 16;

    // Port widths that the request and response fields fix.
    localparam int IN_WORD_BITS = 16;
    localparam int SCORE_BITS   = 17;

    // Derived widths.
    localparam int FIRST_AW    = (FIRST_ENTRIES > 1) ? $clog2(FIRST_ENTRIES) : 1;
    localparam int PAIR_AW     = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int FIRST_CW    = $clog2(FIRST_ENTRIES + 1);
    localparam int PAIR_CW     = $clog2(PAIR_ENTRIES + 1);
    localparam int MAX_ENTRIES = (FIRST_ENTRIES > PAIR_ENTRIES) ? FIRST_ENTRIES : PAIR_ENTRIES;
    localparam int IDX_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_BITS    = ((COUNT_BITS > SCORE_BITS) ? COUNT_BITS : SCORE_BITS) + 1;

    typedef logic [WORD_ID_BITS-1:0] t_id;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [SCORE_BITS-1:0]   t_score;

    localparam t_score SCORE_MAX = '1;
    localparam t_count COUNT_MAX = '1;

    // Request type codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Response status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage

@@ rtl/wpft_datapath.sv @@
// Datapath of the word-pair frequency table: request registers, the first-word
// and pair stores, the scan pipeline, the update logic and the response registers.
// Depends on wpft_pkg.
module wpft_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wpft_pkg::t_cmd                   i_cmd,
    output wpft_pkg::t_stat                  o_stat,
    input  logic                             i_req_type,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_first_word,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_second_word,
    output logic [wpft_pkg::SCORE_BITS-1:0]  o_score,
    output logic                             o_status
);

    // Stores. Entries are never removed, so entries below the fill count are the
    // valid ones and the lowest free slot is always the fill count.
    wpft_pkg::t_id    first_mem [wpft_pkg::FIRST_ENTRIES];
    wpft_pkg::t_id    pfirst_mem [wpft_pkg::PAIR_ENTRIES];
    wpft_pkg::t_id    psecond_mem [wpft_pkg::PAIR_ENTRIES];
    wpft_pkg::t_count count_mem [wpft_pkg::PAIR_ENTRIES];

    logic                          r_req_type;
    wpft_pkg::t_id                 r_a;
    wpft_pkg::t_id                 r_b;
    logic [wpft_pkg::FIRST_CW-1:0] r_first_fill;
    logic [wpft_pkg::PAIR_CW-1:0]  r_pair_fill;
    logic [wpft_pkg::IDX_W-1:0]    r_idx;
    logic                          r_rd_f_vld;
    logic                          r_rd_p_vld;
    logic [wpft_pkg::PAIR_AW-1:0]  r_rd_idx;
    wpft_pkg::t_id                 r_first_q;
    wpft_pkg::t_id                 r_pfirst_q;
    wpft_pkg::t_id                 r_psecond_q;
    wpft_pkg::t_count              r_count_q;
    logic                          r_f_hit;
    logic                          r_p_hit;
    logic [wpft_pkg::PAIR_AW-1:0]  r_p_idx;
    wpft_pkg::t_count              r_p_cnt;
    wpft_pkg::t_score              r_score;
    logic                          r_status;

    logic [wpft_pkg::IDX_W-1:0]    first_fill_ext;
    logic [wpft_pkg::IDX_W-1:0]    pair_fill_ext;
    logic [wpft_pkg::IDX_W-1:0]    scan_len;
    logic                          scan_done;
    logic                          f_rd_en;
    logic                          p_rd_en;
    logic                          f_match;
    logic                          p_match;
    logic                          first_full;
    logic                          pair_full;
    logic                          dropped;
    logic                          do_insert;
    logic [wpft_pkg::SUM_BITS-1:0] sum;
    wpft_pkg::t_score              lookup_score;
    wpft_pkg::t_count              inc_count;

    // Scan control: one entry of each store is read per cycle.
    always_comb begin
        first_fill_ext = wpft_pkg::IDX_W'(r_first_fill);
        pair_fill_ext  = wpft_pkg::IDX_W'(r_pair_fill);
        scan_len       = (first_fill_ext > pair_fill_ext) ? first_fill_ext : pair_fill_ext;
        scan_done      = (r_idx == scan_len);
        f_rd_en        = i_cmd.scan && (r_idx < first_fill_ext);
        p_rd_en        = i_cmd.scan && (r_idx < pair_fill_ext);
        f_match        = i_cmd.scan && r_rd_f_vld && (r_first_q == r_a);
        p_match        = i_cmd.scan && r_rd_p_vld && (r_pfirst_q == r_a) &&
                         (r_psecond_q == r_b);
    end

    assign o_stat.scan_done = scan_done;

    // Update decision and lookup score with saturation.
    always_comb begin
        first_full   = (r_first_fill == wpft_pkg::FIRST_CW'(wpft_pkg::FIRST_ENTRIES));
        pair_full    = (r_pair_fill == wpft_pkg::PAIR_CW'(wpft_pkg::PAIR_ENTRIES));
        dropped      = (!r_f_hit && first_full) || (!r_p_hit && pair_full);
        do_insert    = i_cmd.commit && (r_req_type == wpft_pkg::REQ_INSERT) && !dropped;
        sum          = wpft_pkg::SUM_BITS'(r_p_hit ? r_p_cnt : '0) + wpft_pkg::SUM_BITS'(1);
        lookup_score = (sum > wpft_pkg::SUM_BITS'(wpft_pkg::SCORE_MAX)) ?
                       wpft_pkg::SCORE_MAX : sum[wpft_pkg::SCORE_BITS-1:0];
        inc_count    = (r_p_cnt != wpft_pkg::COUNT_MAX) ? r_p_cnt + 1'b1 : r_p_cnt;
    end

    // Request registers, captured when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_type <= i_req_type;
            r_a        <= wpft_pkg::WORD_ID_BITS'(i_first_word);
            r_b        <= wpft_pkg::WORD_ID_BITS'(i_second_word);
        end
    end

    // Scan counter, read-valid pipeline, hit flags and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_fill <= '0;
            r_pair_fill  <= '0;
            r_idx        <= '0;
            r_rd_f_vld   <= 1'b0;
            r_rd_p_vld   <= 1'b0;
            r_f_hit      <= 1'b0;
            r_p_hit      <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx      <= '0;
                r_rd_f_vld <= 1'b0;
                r_rd_p_vld <= 1'b0;
                r_f_hit    <= 1'b0;
                r_p_hit    <= 1'b0;
            end else if (i_cmd.scan) begin
                if (!scan_done) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_rd_f_vld <= f_rd_en;
                r_rd_p_vld <= p_rd_en;
                if (f_match) begin
                    r_f_hit <= 1'b1;
                end
                if (p_match && !r_p_hit) begin
                    r_p_hit <= 1'b1;
                end
            end
            if (do_insert && !r_f_hit) begin
                r_first_fill <= r_first_fill + 1'b1;
            end
            if (do_insert && !r_p_hit) begin
                r_pair_fill <= r_pair_fill + 1'b1;
            end
        end
    end

    // Payload captured with the pair hit: its slot and count.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[wpft_pkg::PAIR_AW-1:0];
        if (p_match && !r_p_hit) begin
            r_p_idx <= r_rd_idx;
            r_p_cnt <= r_count_q;
        end
    end

    // First-word store: written at the fill count, read during the scan.
    always_ff @(posedge i_clk) begin
        if (do_insert && !r_f_hit) begin
            first_mem[r_first_fill[wpft_pkg::FIRST_AW-1:0]] <= r_a;
        end
        if (f_rd_en) begin
            r_first_q <= first_mem[r_idx[wpft_pkg::FIRST_AW-1:0]];
        end
    end

    // Pair identifier stores: written only for a new pair.
    always_ff @(posedge i_clk) begin
        if (do_insert && !r_p_hit) begin
            pfirst_mem[r_pair_fill[wpft_pkg::PAIR_AW-1:0]] <= r_a;
        end
        if (p_rd_en) begin
            r_pfirst_q <= pfirst_mem[r_idx[wpft_pkg::PAIR_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_insert && !r_p_hit) begin
            psecond_mem[r_pair_fill[wpft_pkg::PAIR_AW-1:0]] <= r_b;
        end
        if (p_rd_en) begin
            r_psecond_q <= psecond_mem[r_idx[wpft_pkg::PAIR_AW-1:0]];
        end
    end

    // Pair count store: a new pair starts at one, a known pair counts up to saturation.
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            if (r_p_hit) begin
                count_mem[r_p_idx] <= inc_count;
            end else begin
                count_mem[r_pair_fill[wpft_pkg::PAIR_AW-1:0]] <= wpft_pkg::COUNT_BITS'(1);
            end
        end
        if (p_rd_en) begin
            r_count_q <= count_mem[r_idx[wpft_pkg::PAIR_AW-1:0]];
        end
    end

    // Response registers, loaded when the request commits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_req_type == wpft_pkg::REQ_LOOKUP) begin
                r_score  <= r_f_hit ? lookup_score : '0;
                r_status <= wpft_pkg::STATUS_DONE;
            end else begin
                r_score  <= '0;
                r_status <= dropped ? wpft_pkg::STATUS_DROPPED : wpft_pkg::STATUS_DONE;
            end
        end
    end

    assign o_score  = r_score;
    assign o_status = r_status;

`ifndef SYNTHESIS
    // The fill counts never pass the store sizes.
    a_first_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_fill <= wpft_pkg::FIRST_CW'(wpft_pkg::FIRST_ENTRIES))
        else $error("first-word fill count exceeds the store size");

    a_pair_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_fill <= wpft_pkg::PAIR_CW'(wpft_pkg::PAIR_ENTRIES))
        else $error("pair fill count exceeds the store size");

    // Every new first word comes with a new pair, so the pair store fills no slower.
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        first_fill_ext <= pair_fill_ext)
        else $error("first-word store holds more entries than the pair store");

    // A dropped insert leaves both stores untouched.
    a_drop_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_req_type == wpft_pkg::REQ_INSERT) && dropped) |=>
        ($stable(r_first_fill) && $stable(r_pair_fill)))
        else $error("dropped insert changed a fill count");
`endif

endmodule

@@ rtl/wpft_ctrl.sv @@
// Controller of the word-pair frequency table: request and response handshakes
// and the sequencing of scan and commit in the datapath.
// Depends on wpft_pkg.
module wpft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output wpft_pkg::t_cmd  o_cmd,
    input  wpft_pkg::t_stat i_stat
);

    wpft_pkg::t_state r_state;
    wpft_pkg::t_state n_state;
    logic             r_rsp_valid;
    logic             n_rsp_valid;
    logic             rsp_free;

    // State and response-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wpft_pkg::ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Next state and commands. A request is taken while an earlier response still waits.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        rsp_free    = !r_rsp_valid || i_rsp_ready;
        unique case (r_state)
            wpft_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = wpft_pkg::ST_SCAN;
                end
            end
            wpft_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = wpft_pkg::ST_COMMIT;
                end
            end
            wpft_pkg::ST_COMMIT: begin
                if (rsp_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = wpft_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wpft_pkg::ST_IDLE;
            end
        endcase
        if (o_cmd.commit) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

@@ rtl/word_pair_frequency_table_unit.sv @@
// Word-pair frequency table. A request is taken in the idle state. The scan state then reads
// one store entry per cycle, up to the larger of the first and pair fill counts, plus a final
// compare, and the commit state follows; the response is registered at the commit. A new
// request is taken only once the last one has committed, and the commit also waits while an
// earlier response is unread.
// Synchronous active-low reset empties both stores through their fill counts.
module word_pair_frequency_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic                              i_req_type,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_first_word,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_second_word,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic [wpft_pkg::SCORE_BITS-1:0]   o_score,
    output logic                              o_status
);

    wpft_pkg::t_cmd  cmd;
    wpft_pkg::t_stat stat;

    // Sequencing and handshakes.
    wpft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Stores, scan and update.
    wpft_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .o_score       (o_score),
        .o_status      (o_status)
    );

endmodule

@@ bench/pair_score_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the word-pair frequency table: watches both channels, keeps its
// own copy of the first-word and pair stores, predicts each response and compares it.
// Depends on wpft_pkg for widths, types and codes.
module pair_score_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic                              i_req_type,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_first_word,
    input  logic [wpft_pkg::IN_WORD_BITS-1:0] i_second_word,
    input  logic                              i_rsp_valid,
    input  logic                              i_rsp_ready,
    input  logic [wpft_pkg::SCORE_BITS-1:0]   i_score,
    input  logic                              i_status,
    output int                                o_mismatches,
    output int                                o_awaiting
);

    typedef struct packed {
        wpft_pkg::t_score score;
        logic             status;
    } t_answer;

    // Answers still owed by the block, oldest first.
    t_answer predicted_answers[$];

    // Shadow copy of the two stores.
    logic             first_used  [wpft_pkg::FIRST_ENTRIES];
    wpft_pkg::t_id    first_ids   [wpft_pkg::FIRST_ENTRIES];
    logic             pair_used   [wpft_pkg::PAIR_ENTRIES];
    wpft_pkg::t_id    pair_first  [wpft_pkg::PAIR_ENTRIES];
    wpft_pkg::t_id    pair_second [wpft_pkg::PAIR_ENTRIES];
    wpft_pkg::t_count pair_tally  [wpft_pkg::PAIR_ENTRIES];
    int               mismatch_count;

    // Both stores start empty.
    initial begin
        for (int i = 0; i < wpft_pkg::FIRST_ENTRIES; i++) begin
            first_used[i] = 1'b0;
        end
        for (int i = 0; i < wpft_pkg::PAIR_ENTRIES; i++) begin
            pair_used[i] = 1'b0;
        end
        mismatch_count = 0;
        o_mismatches   = 0;
        o_awaiting     = 0;
    end

    // Applies one request to the shadow stores and returns the answer it should get.
    // New entries take the lowest free slot; a full store refuses the whole insert.
    function automatic t_answer score_pair_request(input logic kind, input wpft_pkg::t_id a,
                                                   input wpft_pkg::t_id b);
        int              i;
        int              first_hit;
        int              first_free;
        int              pair_hit;
        int              pair_free;
        longint unsigned total;
        t_answer         ans;
        first_hit  = -1;
        first_free = -1;
        pair_hit   = -1;
        pair_free  = -1;
        ans.score  = '0;
        ans.status = wpft_pkg::STATUS_DONE;
        for (i = 0; i < wpft_pkg::FIRST_ENTRIES; i++) begin
            if (first_used[i]) begin
                if (first_hit < 0 && first_ids[i] == a) first_hit = i;
            end else if (first_free < 0) begin
                first_free = i;
            end
        end
        for (i = 0; i < wpft_pkg::PAIR_ENTRIES; i++) begin
            if (pair_used[i]) begin
                if (pair_hit < 0 && pair_first[i] == a && pair_second[i] == b) pair_hit = i;
            end else if (pair_free < 0) begin
                pair_free = i;
            end
        end
        if (kind == wpft_pkg::REQ_LOOKUP) begin
            if (first_hit >= 0) begin
                total = 1;
                if (pair_hit >= 0) total += pair_tally[pair_hit];
                ans.score = (total > wpft_pkg::SCORE_MAX) ? wpft_pkg::SCORE_MAX :
                            wpft_pkg::t_score'(total);
            end
        end else if ((first_hit < 0 && first_free < 0) || (pair_hit < 0 && pair_free < 0)) begin
            ans.status = wpft_pkg::STATUS_DROPPED;
        end else begin
            if (first_hit < 0) begin
                first_used[first_free] = 1'b1;
                first_ids[first_free]  = a;
            end
            if (pair_hit < 0) begin
                pair_used[pair_free]   = 1'b1;
                pair_first[pair_free]  = a;
                pair_second[pair_free] = b;
                pair_tally[pair_free]  = 1;
            end else if (pair_tally[pair_hit] != wpft_pkg::COUNT_MAX) begin
                pair_tally[pair_hit]++;
            end
        end
        return ans;
    endfunction

    // Responses are compared before the request of the same edge is predicted, since
    // no response can come at the same edge as its own request.
    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.score  = i_score;
                got.status = i_status;
                if (predicted_answers.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("response with no request outstanding: score %0d status %0d",
                                 got.score, got.status);
                    end
                    mismatch_count++;
                end else begin
                    want = predicted_answers.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display(
                                "mismatch: expected score %0d status %0d, got %0d status %0d",
                                want.score, want.status, got.score, got.status);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predicted_answers.push_back(
                    score_pair_request(i_req_type, wpft_pkg::t_id'(i_first_word),
                                       wpft_pkg::t_id'(i_second_word)));
            end
        end
        o_mismatches <= mismatch_count;
        o_awaiting   <= predicted_answers.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Bench top for the word-pair frequency table: clock, reset, request and response stimulus
// and the verdict. Depends on wpft_pkg, word_pair_frequency_table_unit and pair_score_checker.
module testbench;

    localparam int RANDOM_ITEMS = 340;
    localparam int WORD_POOL    = 40;
    localparam longint unsigned CYCLE_LIMIT =
        64'd4 * (RANDOM_ITEMS + wpft_pkg::FIRST_ENTRIES + 200) *
        (wpft_pkg::PAIR_ENTRIES + 3 + 64);

    typedef bit [wpft_pkg::WORD_ID_BITS-1:0]   t_word_key;
    typedef bit [2*wpft_pkg::WORD_ID_BITS-1:0] t_pair_key;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_req_valid;
    logic                              o_req_ready;
    logic                              i_req_type;
    logic [wpft_pkg::IN_WORD_BITS-1:0] i_first_word;
    logic [wpft_pkg::IN_WORD_BITS-1:0] i_second_word;
    logic                              o_rsp_valid;
    logic                              i_rsp_ready;
    logic [wpft_pkg::SCORE_BITS-1:0]   o_score;
    logic                              o_status;
    int                                mismatches;
    int                                awaiting;
    int                                req_idle_pct = 0;
    int                                rsp_idle_pct = 0;

    // What the table holds, as far as stimulus needs it to aim at hits and full stores.
    bit                                first_known[t_word_key];
    bit                                pair_known[t_pair_key];
    t_word_key                         first_list[$];
    t_pair_key                         pair_list[$];
    logic [wpft_pkg::IN_WORD_BITS-1:0] word_pool [WORD_POOL];

    word_pair_frequency_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_score       (o_score),
        .o_status      (o_status)
    );

    pair_score_checker score_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .i_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .i_score       (o_score),
        .i_status      (o_status),
        .o_mismatches  (mismatches),
        .o_awaiting    (awaiting)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The response side stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // Either a word from a small pool, so that words recur, or any word at all.
    function automatic logic [wpft_pkg::IN_WORD_BITS-1:0] pick_word();
        if ($urandom_range(1) == 0) return word_pool[$urandom_range(WORD_POOL - 1)];
        return wpft_pkg::IN_WORD_BITS'($urandom());
    endfunction

    // Presents one request after a random gap and holds it until it is taken.
    task automatic issue_request(input logic kind,
                                 input logic [wpft_pkg::IN_WORD_BITS-1:0] a,
                                 input logic [wpft_pkg::IN_WORD_BITS-1:0] b);
        t_word_key fa;
        t_pair_key pk;
        fa = t_word_key'(a);
        pk = {fa, t_word_key'(b)};
        while ($urandom_range(99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_req_type    <= kind;
        i_first_word  <= a;
        i_second_word <= b;
        do @(posedge i_clk); while (!o_req_ready);
        // An insert that needs a slot in a full store leaves the table as it was.
        if (kind == wpft_pkg::REQ_INSERT &&
            !((!first_known.exists(fa) && first_known.num() >= wpft_pkg::FIRST_ENTRIES) ||
              (!pair_known.exists(pk) && pair_known.num() >= wpft_pkg::PAIR_ENTRIES))) begin
            if (!first_known.exists(fa)) begin
                first_known[fa] = 1'b1;
                first_list.push_back(fa);
            end
            if (!pair_known.exists(pk)) begin
                pair_known[pk] = 1'b1;
                pair_list.push_back(pk);
            end
        end
    endtask

    // Mostly pair occurrences followed by a few scores of that pair and its neighbours;
    // the rest is arbitrary requests over the whole word range.
    task automatic run_random(input int count);
        int                                done;
        int                                extra;
        logic [wpft_pkg::IN_WORD_BITS-1:0] a;
        logic [wpft_pkg::IN_WORD_BITS-1:0] b;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 75) begin
                if (pair_list.size() != 0 && $urandom_range(2) == 0) begin
                    {a, b} = pair_list[$urandom_range(pair_list.size() - 1)];
                end else begin
                    a = pick_word();
                    b = pick_word();
                end
                issue_request(wpft_pkg::REQ_INSERT, a, b);
                extra = $urandom_range(2);
                repeat (extra) begin
                    case ($urandom_range(2))
                        0: issue_request(wpft_pkg::REQ_LOOKUP, a, b);
                        1: issue_request(wpft_pkg::REQ_LOOKUP, a, pick_word());
                        default: issue_request(wpft_pkg::REQ_LOOKUP, pick_word(), b);
                    endcase
                end
                done += 1 + extra;
            end else begin
                issue_request(1'($urandom_range(1)), wpft_pkg::IN_WORD_BITS'($urandom()),
                              wpft_pkg::IN_WORD_BITS'($urandom()));
                done++;
            end
        end
    endtask

    // Fills the first-word store, then probes the refusals and the entries that remain usable.
    task automatic fill_first_store();
        logic [wpft_pkg::IN_WORD_BITS-1:0] a;
        logic [wpft_pkg::IN_WORD_BITS-1:0] b;
        t_pair_key                         pk;
        while (first_known.num() < wpft_pkg::FIRST_ENTRIES) begin
            do a = wpft_pkg::IN_WORD_BITS'($urandom());
            while (first_known.exists(t_word_key'(a)));
            issue_request(wpft_pkg::REQ_INSERT, a, wpft_pkg::IN_WORD_BITS'($urandom()));
        end
        // A new first word no longer fits, and so stays unseen.
        repeat (2) begin
            do a = wpft_pkg::IN_WORD_BITS'($urandom());
            while (first_known.exists(t_word_key'(a)));
            issue_request(wpft_pkg::REQ_INSERT, a, pick_word());
            issue_request(wpft_pkg::REQ_LOOKUP, a, pick_word());
        end
        // New words are refused, while known words still take new pairs and pairs still count.
        repeat (16) begin
            case ($urandom_range(2))
                0: begin
                    do a = wpft_pkg::IN_WORD_BITS'($urandom());
                    while (first_known.exists(t_word_key'(a)));
                    issue_request(wpft_pkg::REQ_INSERT, a, pick_word());
                end
                1: begin
                    a = first_list[$urandom_range(first_list.size() - 1)];
                    do b = wpft_pkg::IN_WORD_BITS'($urandom());
                    while (pair_known.exists({t_word_key'(a), t_word_key'(b)}));
                    issue_request(wpft_pkg::REQ_INSERT, a, b);
                    issue_request(wpft_pkg::REQ_LOOKUP, a, b);
                end
                default: begin
                    pk = pair_list[$urandom_range(pair_list.size() - 1)];
                    issue_request(wpft_pkg::REQ_INSERT,
                                  pk[2*wpft_pkg::WORD_ID_BITS-1:wpft_pkg::WORD_ID_BITS],
                                  pk[wpft_pkg::WORD_ID_BITS-1:0]);
                    issue_request(wpft_pkg::REQ_LOOKUP,
                                  pk[2*wpft_pkg::WORD_ID_BITS-1:wpft_pkg::WORD_ID_BITS],
                                  pk[wpft_pkg::WORD_ID_BITS-1:0]);
                end
            endcase
        end
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_req_valid   <= 1'b0;
        i_req_type    <= wpft_pkg::REQ_INSERT;
        i_first_word  <= '0;
        i_second_word <= '0;
        word_pool[0] = '0;
        word_pool[1] = '1;
        word_pool[2] = 16'h0001;
        word_pool[3] = 16'h8000;
        for (int i = 4; i < WORD_POOL; i++) begin
            word_pool[i] = wpft_pkg::IN_WORD_BITS'($urandom());
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        req_idle_pct = 11;
        rsp_idle_pct = 82;
        // An empty table scores nothing.
        issue_request(wpft_pkg::REQ_LOOKUP, '0, '0);
        issue_request(wpft_pkg::REQ_LOOKUP, '1, '1);
        // A repeated pair, a seen word with an absent pair, and an unseen word.
        repeat (3) issue_request(wpft_pkg::REQ_INSERT, '0, '0);
        issue_request(wpft_pkg::REQ_LOOKUP, '0, '0);
        issue_request(wpft_pkg::REQ_LOOKUP, '0, 16'h0001);
        issue_request(wpft_pkg::REQ_LOOKUP, 16'h0001, '0);
        // Pairs at the top of the word range, and order within a pair.
        issue_request(wpft_pkg::REQ_INSERT, '1, '1);
        issue_request(wpft_pkg::REQ_LOOKUP, '1, '1);
        issue_request(wpft_pkg::REQ_INSERT, '1, '0);
        issue_request(wpft_pkg::REQ_INSERT, '1, '0);
        issue_request(wpft_pkg::REQ_LOOKUP, '1, '0);
        issue_request(wpft_pkg::REQ_INSERT, '0, '1);
        issue_request(wpft_pkg::REQ_LOOKUP, '0, '1);
        issue_request(wpft_pkg::REQ_LOOKUP, '1, 16'h0001);
        issue_request(wpft_pkg::REQ_INSERT, 16'h5555, 16'hAAAA);
        issue_request(wpft_pkg::REQ_LOOKUP, 16'hAAAA, 16'h5555);
        issue_request(wpft_pkg::REQ_LOOKUP, 16'h5555, 16'hAAAA);
        issue_request(wpft_pkg::REQ_INSERT, 16'hAAAA, 16'h5555);
        issue_request(wpft_pkg::REQ_LOOKUP, 16'hAAAA, 16'h5555);
        run_random(RANDOM_ITEMS / 3);

        req_idle_pct = 82;
        rsp_idle_pct = 11;
        run_random(RANDOM_ITEMS / 3);

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        fill_first_store();

        // Drain, then watch a while longer for stray responses.
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
        repeat (wpft_pkg::PAIR_ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[word_pair_frequency_table_unit] OK");
        end else begin
            $display("[word_pair_frequency_table_unit] ERROR");
        end
        $finish;
    end

    // Ends a run that hangs.
    initial begin : watchdog
        longint unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[word_pair_frequency_table_unit] ERROR");
        $finish;
    end

endmodule
